### hdl/nss_pkg.sv
`default_nettype none
package nss_pkg;

    localparam int CW    = 12;            // coordinate width
    localparam int DW    = CW + 1;        // coordinate difference
    localparam int PW    = 2 * DW + 1;    // dot, cross, len2 (signed)
    localparam int CMW   = PW - 1;        // |cross|
    localparam int LW    = PW - 1;        // len2 (unsigned)
    localparam int SQW   = 2 * CMW;       // cross^2
    localparam int PPW   = CMW + LW;      // one partial product
    localparam int FW    = SQW + LW;      // cross^2 * len2
    localparam int DISTW = 28;
    localparam int WTW   = 16;
    localparam int IDXW  = 6;
    localparam int SEGW  = 7;
    localparam int CFGW  = 28;
    localparam int ENTW  = 4 * CW + 1 + WTW;

    localparam logic [DISTW-1:0] FAR_RESET = DISTW'(2000);

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    localparam logic CFG_SEGMENTS = 1'b0;
    localparam logic CFG_FAR      = 1'b1;

    typedef struct packed {
        logic signed [CW-1:0]  ax;
        logic signed [CW-1:0]  ay;
        logic signed [CW-1:0]  bx;
        logic signed [CW-1:0]  by;
        logic                  left;
        logic signed [WTW-1:0] wt;
    } t_ent;

    typedef struct packed {
        logic load_point;
        logic st_dif;
        logic st_prd;
        logic st_sq;
        logic st_pp;
        logic st_cmp;
        logic div_init;
        logic div_step;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic found;
        logic out_free;
    } t_sts;

endpackage
`default_nettype wire

### hdl/nss_ram.sv
`default_nettype none
module nss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                      i_wdata,
    input  wire logic                                  i_re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

### hdl/nss_ctrl.sv
`default_nettype none
module nss_ctrl #(
    parameter int MAX_SEGMENTS = 64
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    input  wire logic                       i_req_type,
    output logic                            o_ready,
    input  wire logic                       i_cfg_we,
    input  wire logic                       i_cfg_addr,
    input  wire logic [nss_pkg::CFGW-1:0]   i_cfg_data,
    input  wire nss_pkg::t_sts              i_sts,
    output nss_pkg::t_cmd                   o_cmd,
    output logic                            o_rd_en,
    output logic [(MAX_SEGMENTS > 1 ? $clog2(MAX_SEGMENTS) : 1)-1:0] o_idx
);
    import nss_pkg::*;

    localparam int AW  = MAX_SEGMENTS > 1 ? $clog2(MAX_SEGMENTS) : 1;
    localparam int NW  = $clog2(MAX_SEGMENTS + 1);
    localparam int DCW = $clog2(SQW);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RD   = 4'd1;
    localparam logic [3:0] S_DIF  = 4'd2;
    localparam logic [3:0] S_PRD  = 4'd3;
    localparam logic [3:0] S_SQ   = 4'd4;
    localparam logic [3:0] S_PP   = 4'd5;
    localparam logic [3:0] S_CMP  = 4'd6;
    localparam logic [3:0] S_DVS  = 4'd7;
    localparam logic [3:0] S_DIV  = 4'd8;
    localparam logic [3:0] S_OUT  = 4'd9;

    logic [3:0]      r_state, n_state;
    logic [AW-1:0]   r_idx, n_idx;
    logic [DCW-1:0]  r_dcnt, n_dcnt;
    logic [SEGW-1:0] r_seg;
    logic [NW-1:0]   lim;
    logic            accept;
    logic            last;

    assign lim    = (32'(r_seg) > MAX_SEGMENTS) ? NW'(MAX_SEGMENTS) : NW'(r_seg);
    assign last   = (NW'(r_idx) + NW'(1)) == lim;
    assign accept = i_valid && o_ready;
    assign o_ready = (r_state == S_IDLE);
    assign o_idx  = r_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg <= '0;
        end else if (i_cfg_we && i_cfg_addr == CFG_SEGMENTS) begin
            r_seg <= i_cfg_data[SEGW-1:0];
        end
    end

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_dcnt  = r_dcnt;
        o_cmd   = '0;
        o_rd_en = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (accept && i_req_type == REQ_QUERY) begin
                    o_cmd.load_point = 1'b1;
                    n_idx = '0;
                    n_state = (lim == '0) ? S_DVS : S_RD;
                end
            end
            S_RD: begin
                o_rd_en = 1'b1;
                n_state = S_DIF;
            end
            S_DIF: begin
                o_cmd.st_dif = 1'b1;
                n_state = S_PRD;
            end
            S_PRD: begin
                o_cmd.st_prd = 1'b1;
                n_state = S_SQ;
            end
            S_SQ: begin
                o_cmd.st_sq = 1'b1;
                n_state = S_PP;
            end
            S_PP: begin
                o_cmd.st_pp = 1'b1;
                n_state = S_CMP;
            end
            S_CMP: begin
                o_cmd.st_cmp = 1'b1;
                if (last) begin
                    n_state = S_DVS;
                end else begin
                    n_idx = r_idx + AW'(1);
                    n_state = S_RD;
                end
            end
            S_DVS: begin
                n_dcnt = '0;
                if (i_sts.found) begin
                    o_cmd.div_init = 1'b1;
                    n_state = S_DIV;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_dcnt = r_dcnt + DCW'(1);
                if (r_dcnt == DCW'(SQW - 1)) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_dcnt  <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_dcnt  <= n_dcnt;
        end
    end
endmodule
`default_nettype wire

### hdl/nss_dp.sv
`default_nettype none
module nss_dp #(
    parameter int MAX_SEGMENTS = 64
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire nss_pkg::t_cmd                     i_cmd,
    output nss_pkg::t_sts                          o_sts,
    input  wire logic [(MAX_SEGMENTS > 1 ? $clog2(MAX_SEGMENTS) : 1)-1:0] i_idx,
    input  wire logic [nss_pkg::ENTW-1:0]          i_rd_data,
    input  wire logic signed [nss_pkg::CW-1:0]     i_point_x,
    input  wire logic signed [nss_pkg::CW-1:0]     i_point_y,
    input  wire logic                              i_cfg_we,
    input  wire logic                              i_cfg_addr,
    input  wire logic [nss_pkg::CFGW-1:0]          i_cfg_data,
    input  wire logic                              i_ready,
    output logic                                   o_valid,
    output logic                                   o_found,
    output logic [nss_pkg::IDXW-1:0]               o_nearest_index,
    output logic [nss_pkg::DISTW-1:0]              o_dist_sq,
    output logic signed [nss_pkg::CW-1:0]          o_near_ax,
    output logic signed [nss_pkg::CW-1:0]          o_near_ay,
    output logic signed [nss_pkg::CW-1:0]          o_near_bx,
    output logic signed [nss_pkg::CW-1:0]          o_near_by,
    output logic signed [nss_pkg::WTW-1:0]         o_dir_out,
    output logic                                   o_now_active
);
    import nss_pkg::*;

    localparam int AW = MAX_SEGMENTS > 1 ? $clog2(MAX_SEGMENTS) : 1;

    t_ent                  ent, r_cur, r_bent;
    logic [DISTW-1:0]      r_far;
    logic signed [CW-1:0]  r_px, r_py;
    logic signed [DW-1:0]  r_dx, r_dy, r_ux, r_uy;
    logic signed [PW-1:0]  r_len2, r_dot, r_crs;
    logic                  r_ok, r_left, r_bleft, r_found;
    logic [CMW-1:0]        cmag;
    logic [SQW-1:0]        r_c2, r_bc2;
    logic [LW-1:0]         r_lcur, r_bl;
    logic [PPW-1:0]        r_a_hi, r_a_lo, r_b_hi, r_b_lo;
    logic [FW-1:0]         prod_a, prod_b;
    logic                  win;
    logic [AW-1:0]         r_bidx;
    logic [SQW-1:0]        r_dq;
    logic [LW-1:0]         r_rem;
    logic [LW:0]           trial;
    logic                  ge;
    logic                  match;
    logic [DISTW-1:0]      dist_val;
    logic                  r_out_vld;

    assign ent = t_ent'(i_rd_data);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_far <= FAR_RESET;
        end else if (i_cfg_we && i_cfg_addr == CFG_FAR) begin
            r_far <= i_cfg_data[DISTW-1:0];
        end
    end

    assign cmag   = r_crs[PW-1] ? CMW'(-r_crs) : CMW'(r_crs);
    assign prod_a = (FW'(r_a_hi) << CMW) + FW'(r_a_lo);
    assign prod_b = (FW'(r_b_hi) << CMW) + FW'(r_b_lo);
    // strict less keeps the earlier slot on a tie
    assign win    = r_ok && (!r_found || prod_a < prod_b);

    assign trial  = {r_rem, r_dq[SQW-1]};
    assign ge     = trial >= {1'b0, r_bl};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_point) begin
            r_px <= i_point_x;
            r_py <= i_point_y;
        end
        if (i_cmd.st_dif) begin
            r_cur <= ent;
            r_dx  <= DW'(ent.bx) - DW'(ent.ax);
            r_dy  <= DW'(ent.by) - DW'(ent.ay);
            r_ux  <= DW'(r_px) - DW'(ent.ax);
            r_uy  <= DW'(r_py) - DW'(ent.ay);
        end
        if (i_cmd.st_prd) begin
            r_len2 <= PW'(r_dx) * PW'(r_dx) + PW'(r_dy) * PW'(r_dy);
            r_dot  <= PW'(r_ux) * PW'(r_dx) + PW'(r_uy) * PW'(r_dy);
            r_crs  <= PW'(r_dx) * PW'(r_uy) - PW'(r_dy) * PW'(r_ux);
        end
        if (i_cmd.st_sq) begin
            r_ok   <= (r_len2 != '0) && !r_dot[PW-1] && (r_dot <= r_len2);
            r_c2   <= SQW'(cmag) * SQW'(cmag);
            r_lcur <= LW'(r_len2);
            r_left <= !r_crs[PW-1] && (r_crs != '0);
        end
        if (i_cmd.st_pp) begin
            // cross-multiplied compare: c^2 * bestL vs bestc^2 * L
            r_a_hi <= PPW'(r_c2[SQW-1:CMW]) * PPW'(r_bl);
            r_a_lo <= PPW'(r_c2[CMW-1:0]) * PPW'(r_bl);
            r_b_hi <= PPW'(r_bc2[SQW-1:CMW]) * PPW'(r_lcur);
            r_b_lo <= PPW'(r_bc2[CMW-1:0]) * PPW'(r_lcur);
        end
        if (i_cmd.st_cmp && win) begin
            r_bc2   <= r_c2;
            r_bl    <= r_lcur;
            r_bidx  <= i_idx;
            r_bent  <= r_cur;
            r_bleft <= r_left;
        end
        if (i_cmd.div_init) begin
            r_dq  <= r_bc2;
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= ge ? LW'(trial - {1'b0, r_bl}) : LW'(trial);
            r_dq  <= {r_dq[SQW-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_cmd.load_point) begin
            r_found <= 1'b0;
        end else if (i_cmd.st_cmp && win) begin
            r_found <= 1'b1;
        end
    end

    assign match    = (r_bleft == r_bent.left);
    assign dist_val = (|r_dq[SQW-1:DISTW]) ? '1 : r_dq[DISTW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_found <= r_found;
            if (r_found) begin
                o_nearest_index <= IDXW'(r_bidx);
                o_dist_sq       <= dist_val;
                o_near_ax       <= r_bent.ax;
                o_near_ay       <= r_bent.ay;
                o_near_bx       <= r_bent.bx;
                o_near_by       <= r_bent.by;
                o_dir_out       <= match ? r_bent.wt : '0;
                o_now_active    <= match;
            end else begin
                o_nearest_index <= '0;
                o_dist_sq       <= r_far;
                o_near_ax       <= '0;
                o_near_ay       <= '0;
                o_near_bx       <= '0;
                o_near_by       <= '0;
                o_dir_out       <= '0;
                o_now_active    <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_vld <= 1'b1;
        end else if (i_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    assign o_valid        = r_out_vld;
    assign o_sts.found    = r_found;
    assign o_sts.out_free = !r_out_vld || i_ready;
endmodule
`default_nettype wire

### hdl/nearest_segment_search_unit.sv
// channel | handshake           | words
// --------+---------------------+------------------------------------------
// in      | i_valid / o_ready   | req_type, entry_index, segment, point
// out     | o_valid / i_ready   | found, index, dist_sq, endpoints, dir
// cfg     | i_cfg_we            | i_cfg_addr, i_cfg_data (no read-back)
//
// Segment write: goes through the table write port, no output word.
// Query: the walk reads one table entry per 6-step pass over
// N = min(segments_in_use, MAX_SEGMENTS) entries; with a winner, a 52-step
// divider then produces floor(cross^2/len2).
// Reset is synchronous; the table holds garbage until written.
// A query may start while the previous output word still waits; it
// stalls in its final step until the output register frees up.
`default_nettype none
module nearest_segment_search_unit #(
    parameter int MAX_SEGMENTS = 64
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_ready,
    input  wire logic                              i_req_type,
    input  wire logic [nss_pkg::IDXW-1:0]          i_entry_index,
    input  wire logic signed [nss_pkg::CW-1:0]     i_end_ax,
    input  wire logic signed [nss_pkg::CW-1:0]     i_end_ay,
    input  wire logic signed [nss_pkg::CW-1:0]     i_end_bx,
    input  wire logic signed [nss_pkg::CW-1:0]     i_end_by,
    input  wire logic                              i_blocks_left,
    input  wire logic signed [nss_pkg::WTW-1:0]    i_direction_weight,
    input  wire logic signed [nss_pkg::CW-1:0]     i_point_x,
    input  wire logic signed [nss_pkg::CW-1:0]     i_point_y,
    input  wire logic                              i_cfg_we,
    input  wire logic                              i_cfg_addr,
    input  wire logic [nss_pkg::CFGW-1:0]          i_cfg_data,
    output logic                                   o_valid,
    input  wire logic                              i_ready,
    output logic                                   o_found,
    output logic [nss_pkg::IDXW-1:0]               o_nearest_index,
    output logic [nss_pkg::DISTW-1:0]              o_dist_sq,
    output logic signed [nss_pkg::CW-1:0]          o_near_ax,
    output logic signed [nss_pkg::CW-1:0]          o_near_ay,
    output logic signed [nss_pkg::CW-1:0]          o_near_bx,
    output logic signed [nss_pkg::CW-1:0]          o_near_by,
    output logic signed [nss_pkg::WTW-1:0]         o_dir_out,
    output logic                                   o_now_active
);
    import nss_pkg::*;

    localparam int AW = MAX_SEGMENTS > 1 ? $clog2(MAX_SEGMENTS) : 1;

    t_cmd            cmd;
    t_sts            sts;
    t_ent            wr_ent;
    logic            rd_en;
    logic [AW-1:0]   idx;
    logic            wr_en;
    logic [ENTW-1:0] rd_data;

    assign wr_en = i_valid && o_ready && (i_req_type == REQ_WRITE)
                   && (32'(i_entry_index) < MAX_SEGMENTS);

    assign wr_ent.ax   = i_end_ax;
    assign wr_ent.ay   = i_end_ay;
    assign wr_ent.bx   = i_end_bx;
    assign wr_ent.by   = i_end_by;
    assign wr_ent.left = i_blocks_left;
    assign wr_ent.wt   = i_direction_weight;

    nss_ram #(
        .WIDTH (ENTW),
        .DEPTH (MAX_SEGMENTS)
    ) u_tab (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (AW'(i_entry_index)),
        .i_wdata (wr_ent),
        .i_re    (rd_en),
        .i_raddr (idx),
        .o_rdata (rd_data)
    );

    nss_ctrl #(
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_req_type (i_req_type),
        .o_ready    (o_ready),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_rd_en    (rd_en),
        .o_idx      (idx)
    );

    nss_dp #(
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_idx           (idx),
        .i_rd_data       (rd_data),
        .i_point_x       (i_point_x),
        .i_point_y       (i_point_y),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_data      (i_cfg_data),
        .i_ready         (i_ready),
        .o_valid         (o_valid),
        .o_found         (o_found),
        .o_nearest_index (o_nearest_index),
        .o_dist_sq       (o_dist_sq),
        .o_near_ax       (o_near_ax),
        .o_near_ay       (o_near_ay),
        .o_near_bx       (o_near_bx),
        .o_near_by       (o_near_by),
        .o_dir_out       (o_dir_out),
        .o_now_active    (o_now_active)
    );

`ifndef ASSERT_OFF
    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_found |-> o_nearest_index == '0 && o_dir_out == '0 && !o_now_active)
        else $error("empty result carries segment data");

    a_active_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_now_active |-> o_found)
        else $error("active flag without a winner");

    a_rise_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(!o_ready))
        else $error("result word without a query in flight");

    a_wr_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> !rd_en)
        else $error("table write during walk");
`endif
endmodule
`default_nettype wire

### tb/nearest_segment_search_unit_tb.sv
`default_nettype none
module nearest_segment_search_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import nss_pkg::*;

    localparam int NSEG       = 64;
    localparam int STALL_MAX  = 20000;
    localparam logic [DISTW-1:0] DIST_SAT = '1;

    typedef struct {
        logic                  req;
        logic [IDXW-1:0]       idx;
        logic signed [CW-1:0]  ax, ay, bx, by;
        logic                  left;
        logic signed [WTW-1:0] wt;
        logic signed [CW-1:0]  px, py;
    } req_word_t;

    typedef struct {
        logic                  found;
        logic [IDXW-1:0]       idx;
        logic [DISTW-1:0]      dsq;
        logic signed [CW-1:0]  ax, ay, bx, by;
        logic signed [WTW-1:0] dir;
        logic                  act;
    } hit_word_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_ready;
    logic                  i_req_type = REQ_WRITE;
    logic [IDXW-1:0]       i_entry_index = '0;
    logic signed [CW-1:0]  i_end_ax = '0, i_end_ay = '0, i_end_bx = '0, i_end_by = '0;
    logic                  i_blocks_left = 1'b0;
    logic signed [WTW-1:0] i_direction_weight = '0;
    logic signed [CW-1:0]  i_point_x = '0, i_point_y = '0;
    logic                  i_cfg_we = 1'b0;
    logic                  i_cfg_addr = CFG_SEGMENTS;
    logic [CFGW-1:0]       i_cfg_data = '0;
    logic                  o_valid;
    logic                  i_ready = 1'b0;
    logic                  o_found;
    logic [IDXW-1:0]       o_nearest_index;
    logic [DISTW-1:0]      o_dist_sq;
    logic signed [CW-1:0]  o_near_ax, o_near_ay, o_near_bx, o_near_by;
    logic signed [WTW-1:0] o_dir_out;
    logic                  o_now_active;

    nearest_segment_search_unit #(.MAX_SEGMENTS(NSEG)) dut (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // segment table mirror
    logic signed [CW-1:0]  seg_ax[NSEG], seg_ay[NSEG], seg_bx[NSEG], seg_by[NSEG];
    logic                  seg_left[NSEG];
    logic signed [WTW-1:0] seg_wt[NSEG];
    logic                  seg_act[NSEG];
    logic [SEGW-1:0]       seg_count = '0;
    logic [DISTW-1:0]      far_dist = FAR_RESET;

    hit_word_t hits_pending[$];
    int errors = 0;
    int n_writes = 0, n_queries = 0, n_found = 0, n_checked = 0;
    bit steady = 0;

    function automatic hit_word_t nearest_hit(logic signed [CW-1:0] px,
                                              logic signed [CW-1:0] py);
        hit_word_t h;
        int n, best;
        longint dx, dy, ux, uy, len2, dot, cr, bcr;
        logic [127:0] c2, best_c2, best_len;
        bit hit;
        h = '{default: '0};
        hit = 0;
        best = 0;
        bcr = 0;
        best_c2 = '0;
        best_len = 128'd1;
        n = (seg_count > NSEG) ? NSEG : int'(seg_count);
        for (int i = 0; i < n; i++) begin
            dx = seg_bx[i] - seg_ax[i];
            dy = seg_by[i] - seg_ay[i];
            ux = px - seg_ax[i];
            uy = py - seg_ay[i];
            len2 = dx * dx + dy * dy;
            dot = ux * dx + uy * dy;
            if (len2 == 0 || dot < 0 || dot > len2)
                continue;
            cr = dx * uy - dy * ux;
            c2 = 128'(cr * cr);
            // exact ratio compare, strict so the lowest slot keeps a tie
            if (!hit || c2 * best_len < best_c2 * 128'(len2)) begin
                hit = 1;
                best = i;
                best_c2 = c2;
                best_len = 128'(len2);
                bcr = cr;
            end
        end
        if (!hit) begin
            h.dsq = far_dist;
            return h;
        end
        h.found = 1'b1;
        h.idx = best[IDXW-1:0];
        h.dsq = (best_c2 / best_len > 128'(DIST_SAT)) ? DIST_SAT
                                                      : DISTW'(best_c2 / best_len);
        h.ax = seg_ax[best];
        h.ay = seg_ay[best];
        h.bx = seg_bx[best];
        h.by = seg_by[best];
        // on the line counts as right
        h.act = ((bcr > 0) == seg_left[best]);
        h.dir = h.act ? seg_wt[best] : '0;
        seg_act[best] = h.act;
        return h;
    endfunction

    function automatic int pick_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // output side stalls
    int rdy_left = 0;
    always @(posedge i_clk) begin
        if (steady) begin
            i_ready <= 1'b1;
        end else if (rdy_left > 0) begin
            rdy_left <= rdy_left - 1;
        end else begin
            i_ready <= ~i_ready;
            rdy_left <= i_ready ? pick_gap() : $urandom_range(0, 12);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        hit_word_t e;
        if (i_rst_n && o_valid && i_ready) begin
            n_checked++;
            if (hits_pending.size() == 0) begin
                $display("%0t: unexpected result word index=%0d", $time, o_nearest_index);
                errors++;
            end else begin
                e = hits_pending.pop_front();
                if (o_found !== e.found || o_nearest_index !== e.idx || o_dist_sq !== e.dsq ||
                    o_near_ax !== e.ax || o_near_ay !== e.ay || o_near_bx !== e.bx ||
                    o_near_by !== e.by || o_dir_out !== e.dir || o_now_active !== e.act) begin
                    $display({"%0t: mismatch exp found=%0d idx=%0d dist=%0d a=(%0d,%0d) ",
                              "b=(%0d,%0d) dir=%0d act=%0d"},
                             $time, e.found, e.idx, e.dsq, e.ax, e.ay, e.bx, e.by,
                             e.dir, e.act);
                    $display({"%0t:          got found=%0d idx=%0d dist=%0d a=(%0d,%0d) ",
                              "b=(%0d,%0d) dir=%0d act=%0d"},
                             $time, o_found, o_nearest_index, o_dist_sq, o_near_ax,
                             o_near_ay, o_near_bx, o_near_by, o_dir_out, o_now_active);
                    errors++;
                end
            end
        end
    end

    // watchdog on handshake progress
    int quiet = 0;
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || i_cfg_we || !i_rst_n) begin
            quiet <= 0;
        end else if (quiet >= STALL_MAX) begin
            $display("%0t: no progress for %0d cycles", $time, STALL_MAX);
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    task automatic send_word(req_word_t w);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_req_type <= w.req;
        i_entry_index <= w.idx;
        i_end_ax <= w.ax;
        i_end_ay <= w.ay;
        i_end_bx <= w.bx;
        i_end_by <= w.by;
        i_blocks_left <= w.left;
        i_direction_weight <= w.wt;
        i_point_x <= w.px;
        i_point_y <= w.py;
        forever begin
            @(negedge i_clk);
            if (o_ready) begin
                @(posedge i_clk);
                break;
            end
        end
        if (w.req == REQ_WRITE) begin
            seg_ax[w.idx] = w.ax;
            seg_ay[w.idx] = w.ay;
            seg_bx[w.idx] = w.bx;
            seg_by[w.idx] = w.by;
            seg_left[w.idx] = w.left;
            seg_wt[w.idx] = w.wt;
            seg_act[w.idx] = 1'b0;
            n_writes++;
        end else begin
            hits_pending.push_back(nearest_hit(w.px, w.py));
            n_queries++;
            if (hits_pending[$].found)
                n_found++;
        end
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (hits_pending.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic set_reg(logic addr, logic [CFGW-1:0] data);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (addr == CFG_SEGMENTS)
            seg_count = data[SEGW-1:0];
        else
            far_dist = data[DISTW-1:0];
    endtask

    function automatic logic signed [CW-1:0] clamp(int v);
        if (v > 2047)
            return 12'sd2047;
        if (v < -2048)
            return -12'sd2048;
        return v[CW-1:0];
    endfunction

    function automatic req_word_t rand_word();
        req_word_t w;
        w.req = 1'($urandom_range(0, 1));
        w.idx = IDXW'($urandom);
        w.ax = CW'($urandom);
        w.ay = CW'($urandom);
        w.bx = CW'($urandom);
        w.by = CW'($urandom);
        w.left = 1'($urandom);
        w.wt = WTW'($urandom);
        w.px = CW'($urandom);
        w.py = CW'($urandom);
        return w;
    endfunction

    function automatic req_word_t seg_write(int idx, int ax, int ay, int bx, int by,
                                            bit left, int wt);
        req_word_t w;
        w = rand_word();
        w.req = REQ_WRITE;
        w.idx = IDXW'(idx);
        w.ax = CW'(ax);
        w.ay = CW'(ay);
        w.bx = CW'(bx);
        w.by = CW'(by);
        w.left = left;
        w.wt = WTW'(wt);
        return w;
    endfunction

    function automatic req_word_t point_query(int px, int py);
        req_word_t w;
        w = rand_word();
        w.req = REQ_QUERY;
        w.px = CW'(px);
        w.py = CW'(py);
        return w;
    endfunction

    // segment with mostly local extent so that points land on it
    function automatic req_word_t rand_segment(int idx);
        req_word_t w;
        int cx, cy, r, m;
        w = rand_word();
        w.req = REQ_WRITE;
        w.idx = IDXW'(idx);
        m = $urandom_range(0, 9);
        if (m < 6) begin
            r = (m < 3) ? 16 : 400;
            cx = int'($urandom_range(0, 4095)) - 2048;
            cy = int'($urandom_range(0, 4095)) - 2048;
            w.ax = clamp(cx + int'($urandom_range(0, 2 * r)) - r);
            w.ay = clamp(cy + int'($urandom_range(0, 2 * r)) - r);
            w.bx = clamp(cx + int'($urandom_range(0, 2 * r)) - r);
            w.by = clamp(cy + int'($urandom_range(0, 2 * r)) - r);
        end else if (m == 6) begin
            w.bx = w.ax;
            w.by = w.ay;
        end else if (m == 7) begin
            w.ax = $urandom_range(0, 1) ? 12'sd2047 : -12'sd2048;
            w.by = $urandom_range(0, 1) ? 12'sd2047 : -12'sd2048;
        end
        return w;
    endfunction

    // point near slot s: along the segment plus a perpendicular offset
    function automatic req_word_t near_query(int s);
        int dx, dy, t, k;
        dx = seg_bx[s] - seg_ax[s];
        dy = seg_by[s] - seg_ay[s];
        t = $urandom_range(0, 16);
        k = int'($urandom_range(0, 8)) - 4;
        return point_query(clamp(seg_ax[s] + dx * t / 16 - dy * k / 32
                                 + int'($urandom_range(0, 2)) - 1),
                           clamp(seg_ay[s] + dy * t / 16 + dx * k / 32
                                 + int'($urandom_range(0, 2)) - 1));
    endfunction

    task automatic test_reset_state();
        // nothing searched yet: far distance comes back at its reset value
        send_word(point_query(0, 0));
        send_word(point_query(-2048, 2047));
    endtask

    task automatic test_table_fill();
        for (int i = 0; i < NSEG; i++)
            send_word(rand_segment(i));
    endtask

    task automatic test_corner_cases();
        send_word(seg_write(0, -2048, -2048, 2047, 2047, 1'b1, 32767));
        send_word(seg_write(1, 5, 5, 5, 5, 1'b0, 77));
        send_word(seg_write(2, -2048, -2048, 2047, 2047, 1'b0, -32768));
        send_word(seg_write(3, 0, 0, 100, 0, 1'b0, 1234));
        set_reg(CFG_SEGMENTS, CFGW'(4));
        send_word(point_query(0, 0));        // on the line, tie across slots
        send_word(point_query(-2048, 2047)); // left of the diagonal
        send_word(point_query(2047, -2048));
        send_word(point_query(100, 0));      // projection at the far end
        send_word(point_query(50, -7));
        send_word(point_query(50, 7));
        send_word(point_query(-2048, -2048));
        send_word(point_query(2047, 2047));
        send_word(seg_write(0, 0, 0, 10, 0, 1'b0, -1));
        set_reg(CFG_SEGMENTS, CFGW'(2));
        send_word(point_query(500, 500));    // nothing projects
        send_word(point_query(3, -4));
        set_reg(CFG_FAR, '0);
        send_word(point_query(-900, 900));
        set_reg(CFG_FAR, DIST_SAT);
        send_word(point_query(-900, 900));
        set_reg(CFG_SEGMENTS, CFGW'(127));   // count above table size
        send_word(point_query(1, 1));
        send_word(point_query(-1, -1));
        set_reg(CFG_SEGMENTS, CFGW'(65));
        send_word(point_query(-2048, 0));
        set_reg(CFG_SEGMENTS, CFGW'(64));
        send_word(point_query(0, 2047));
    endtask

    task automatic test_random_mix();
        int counts[8] = '{1, 2, 4, 8, 3, 16, 64, 100};
        req_word_t w;
        for (int ph = 0; ph < 8; ph++) begin
            set_reg(CFG_SEGMENTS, CFGW'(counts[ph]));
            set_reg(CFG_FAR, CFGW'($urandom_range(0, 3) == 0 ? $urandom
                                                            : $urandom_range(0, 20000)));
            steady = (ph == 2 || ph == 5);
            for (int k = 0; k < 190; k++) begin
                if ($urandom_range(0, 9) < 3) begin
                    w = rand_segment($urandom_range(0, 9) < 7 ?
                                     $urandom_range(0, (counts[ph] > NSEG ? NSEG : counts[ph]) - 1)
                                     : $urandom_range(0, NSEG - 1));
                end else if ($urandom_range(0, 9) < 8) begin
                    w = near_query($urandom_range(0, (counts[ph] > NSEG ? NSEG : counts[ph]) - 1));
                end else begin
                    w = rand_word();
                    w.req = REQ_QUERY;
                end
                send_word(w);
            end
        end
        steady = 0;
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_state();
        test_table_fill();
        test_corner_cases();
        test_random_mix();
        drain();
        $display("Sent %0d segment writes and %0d queries (%0d with a hit), %0d results checked",
                 n_writes, n_queries, n_found, n_checked);
        $display("Segment counts 0..127 and far distance extremes were exercised");
        if (errors == 0 && hits_pending.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("%0d errors, %0d results missing", errors, hits_pending.size());
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
`default_nettype wire
